>>> rtl/hpt_pkg.sv
// hpt_pkg: shared types and constants of the hpack header table
// used by hpt_ctrl, hpt_datapath and hpack_header_table_top
package hpt_pkg;

  localparam int unsigned TABLE_BYTES    = 4096;
  localparam int unsigned MAX_ENTRIES    = 128;
  localparam int unsigned STATIC_ENTRIES = 61;
  localparam int unsigned ENTRY_OVERHEAD = 32;
  localparam int unsigned LEN_W          = 13;
  localparam logic [LEN_W-1:0] PEND_MAX  = 13'd8191;
  localparam logic [12:0] MAX_SIZE_RESET = 13'd4096;

  typedef enum logic [1:0] {
    RT_BYTE   = 2'd0,
    RT_LOOKUP = 2'd1,
    RT_SIZE   = 2'd2,
    RT_READ   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_IDX = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_PLAIN  = 2'd0,
    RK_STATIC = 2'd1,
    RK_DYN    = 2'd2,
    RK_READ   = 2'd3
  } rsp_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK_WAIT,
    S_READ_WAIT,
    S_COMMIT,
    S_CEV_CHK,
    S_CEV_WAIT,
    S_SEV_CHK,
    S_SEV_WAIT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        is_value;
    logic        last_byte;
    logic        empty_value;
    logic [7:0]  table_index;
    logic        name_only;
    logic [12:0] size_req;
    logic [11:0] byte_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_static;
    logic [5:0]  static_slot;
    logic [11:0] entry_start;
    logic [11:0] name_length;
    logic [11:0] value_length;
    logic [7:0]  read_data;
    logic [7:0]  entry_count;
    logic [12:0] used_size;
  } out_item_t;

  typedef struct packed {
    logic      take;
    logic      wr_byte;
    logic      empty_back;
    logic      set_max;
    logic      rd_look;
    logic      rd_old;
    logic      rd_byte;
    logic      drop;
    logic      commit_fail;
    logic      commit_wr;
    logic      load_out;
    rsp_kind_t kind;
    status_t   status;
  } ctrl_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      empty_value;
    logic      last_byte;
    logic      idx_bad;
    logic      idx_static;
    logic      size_bad;
    logic      too_big;
    logic      evict_commit;
    logic      evict_size;
    logic      out_free;
  } dp_status_t;

endpackage

>>> rtl/hpack_header_table_top.sv
// hpack_header_table_top: hpack dynamic header table with static index map
// depends on hpt_pkg, hpt_ctrl, hpt_datapath
//
// channel   direction  handshake          payload
// in_*      input      in_valid/in_stall   in_item_t
// out_*     output     out_valid/out_stall out_item_t
// cfg_*     input      cfg_we              size_limit (13 bits)
//
// dynamic lookup and byte read wait on a registered memory read;
//   commit and size update evict the oldest entry one at a time
// one item in flight; next item is taken once the result register frees
// reset is synchronous, rings hold no reset value
module hpack_header_table_top import hpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer: decode, eviction loop, result load
  hpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // storage, accounting and result register
  hpt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/hpt_ctrl.sv
// hpt_ctrl: sequencer of the hpack header table
// depends on hpt_pkg; drives commands into hpt_datapath
module hpt_ctrl import hpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = RK_PLAIN;
    cmd.status = ST_OK;
    in_stall  = !((state_r == S_IDLE) && st.out_free);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && st.out_free) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.req_type)
          RT_BYTE: begin
            if (st.empty_value) begin
              cmd.empty_back = 1'b1;
              state_nxt = S_COMMIT;
            end else begin
              cmd.wr_byte = 1'b1;
              if (st.last_byte) state_nxt = S_COMMIT;
              else begin
                cmd.load_out = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          end
          RT_LOOKUP: begin
            if (st.idx_bad) begin
              cmd.load_out = 1'b1;
              cmd.status = ST_BAD_IDX;
              state_nxt = S_IDLE;
            end else if (st.idx_static) begin
              cmd.load_out = 1'b1;
              cmd.kind = RK_STATIC;
              state_nxt = S_IDLE;
            end else begin
              cmd.rd_look = 1'b1;
              state_nxt = S_LOOK_WAIT;
            end
          end
          RT_SIZE: begin
            if (st.size_bad) begin
              cmd.load_out = 1'b1;
              cmd.status = ST_OVER;
              state_nxt = S_IDLE;
            end else begin
              cmd.set_max = 1'b1;
              state_nxt = S_SEV_CHK;
            end
          end
          RT_READ: begin
            cmd.rd_byte = 1'b1;
            state_nxt = S_READ_WAIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LOOK_WAIT: begin
        cmd.load_out = 1'b1;
        cmd.kind = RK_DYN;
        state_nxt = S_IDLE;
      end
      S_READ_WAIT: begin
        cmd.load_out = 1'b1;
        cmd.kind = RK_READ;
        state_nxt = S_IDLE;
      end
      S_COMMIT: begin
        if (st.too_big) begin
          cmd.commit_fail = 1'b1;
          cmd.load_out = 1'b1;
          cmd.status = ST_TOO_BIG;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CEV_CHK;
        end
      end
      S_CEV_CHK: begin
        if (st.evict_commit) begin
          cmd.rd_old = 1'b1;
          state_nxt = S_CEV_WAIT;
        end else begin
          cmd.commit_wr = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CEV_WAIT: begin
        cmd.drop = 1'b1;
        state_nxt = S_CEV_CHK;
      end
      S_SEV_CHK: begin
        if (st.evict_size) begin
          cmd.rd_old = 1'b1;
          state_nxt = S_SEV_WAIT;
        end else begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEV_WAIT: begin
        cmd.drop = 1'b1;
        state_nxt = S_SEV_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/hpt_datapath.sv
// hpt_datapath: byte ring, entry ring, table accounting and result register
// depends on hpt_pkg; commanded by hpt_ctrl
module hpt_datapath import hpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [12:0] cfg_wdata,
  input  ctrl_cmd_t  cmd,
  output dp_status_t st,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int unsigned AW  = $clog2(TABLE_BYTES);
  localparam int unsigned EW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CW  = EW + 1;
  localparam int unsigned WW  = AW + 16;
  localparam int unsigned ENT_W = AW + 2 * LEN_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [16:0] TB_LIM = 17'(TABLE_BYTES);

  in_item_t           req_r;
  logic [AW-1:0]      wptr_r, wptr_nxt;
  logic [EW-1:0]      old_r, old_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [12:0]        used_r, used_nxt;
  logic [12:0]        max_r, lim_r;
  logic [LEN_W-1:0]   pn_r, pn_nxt, pv_r, pv_nxt;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  logic [7:0]         bmem [TABLE_BYTES];
  logic [ENT_W-1:0]   emem [MAX_ENTRIES];
  logic [7:0]         brd_r;
  logic [ENT_W-1:0]   erd_r;
  logic [EW-1:0]      e_ra;
  logic [AW-1:0]      rd_start;
  logic [LEN_W-1:0]   rd_nlen, rd_vlen;

  logic [14:0]        sz, drop_sz;
  logic [13:0]        tot;
  logic [AW-1:0]      new_start;
  logic [15:0]        d, look_pos;
  logic [WW-1:0]      start_ext;

  assign {rd_start, rd_nlen, rd_vlen} = erd_r;
  assign tot     = 14'(pn_r) + 14'(pv_r);
  assign sz      = 15'(tot) + 15'(ENTRY_OVERHEAD);
  assign drop_sz = 15'(rd_nlen) + 15'(rd_vlen) + 15'(ENTRY_OVERHEAD);
  assign new_start = AW'(WW'(wptr_r) - WW'(tot));
  assign d        = 16'(req_r.table_index) - 16'(STATIC_ENTRIES + 1);
  assign look_pos = 16'(old_r) + 16'(cnt_r) - 16'd1 - d;
  assign e_ra     = cmd.rd_look ? look_pos[EW-1:0] : old_r;

  // status toward the sequencer
  always_comb begin
    st.req_type    = req_type_t'(req_r.req_type);
    st.empty_value = req_r.empty_value;
    st.last_byte   = req_r.last_byte;
    st.idx_static  = (req_r.table_index != 8'd0) &&
                     (req_r.table_index <= 8'(STATIC_ENTRIES));
    st.idx_bad     = (req_r.table_index == 8'd0) ||
                     (!st.idx_static && (d >= 16'(cnt_r)));
    st.size_bad    = (req_r.size_req > lim_r) || (17'(req_r.size_req) > TB_LIM);
    st.too_big     = sz > 15'(max_r);
    st.evict_commit = (cnt_r != '0) &&
                      ((16'(used_r) + 16'(sz) > 16'(max_r)) || (cnt_r >= MAX_CNT));
    st.evict_size  = (cnt_r != '0) && (used_r > req_r.size_req);
    st.out_free    = !out_valid_r || !out_stall;
  end

  // state next values
  always_comb begin
    wptr_nxt = wptr_r;
    old_nxt  = old_r;
    cnt_nxt  = cnt_r;
    used_nxt = used_r;
    pn_nxt   = pn_r;
    pv_nxt   = pv_r;
    if (cmd.wr_byte) begin
      wptr_nxt = wptr_r + AW'(1);
      if (req_r.is_value || (pv_r != '0)) begin
        if (pv_r < PEND_MAX) pv_nxt = pv_r + LEN_W'(1);
      end else begin
        if (pn_r < PEND_MAX) pn_nxt = pn_r + LEN_W'(1);
      end
    end
    if (cmd.empty_back) begin
      wptr_nxt = AW'(WW'(wptr_r) - WW'(pv_r));
      pv_nxt   = '0;
    end
    if (cmd.drop) begin
      used_nxt = (drop_sz > 15'(used_r)) ? 13'd0 : 13'(15'(used_r) - drop_sz);
      old_nxt  = old_r + EW'(1);
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) used_nxt = 13'd0;
    end
    if (cmd.commit_fail) begin
      cnt_nxt  = '0;
      used_nxt = 13'd0;
      pn_nxt   = '0;
      pv_nxt   = '0;
    end
    if (cmd.commit_wr) begin
      cnt_nxt  = cnt_r + CW'(1);
      used_nxt = 13'(15'(used_r) + sz);
      pn_nxt   = '0;
      pv_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      old_r  <= '0;
      cnt_r  <= '0;
      used_r <= '0;
      pn_r   <= '0;
      pv_r   <= '0;
      max_r  <= MAX_SIZE_RESET;
      lim_r  <= MAX_SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      old_r  <= old_nxt;
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
      pn_r   <= pn_nxt;
      pv_r   <= pv_nxt;
      if (cmd.set_max) max_r <= req_r.size_req;
      if (cfg_we)      lim_r <= cfg_wdata;
      if (cmd.load_out)    out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) req_r <= in_data;
  end

  // byte ring
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) bmem[wptr_r] <= req_r.data_byte;
    if (cmd.rd_byte) brd_r <= bmem[req_r.byte_addr[AW-1:0]];
  end

  // entry ring
  always_ff @(posedge clk) begin
    if (cmd.commit_wr) emem[EW'(16'(old_r) + 16'(cnt_r))] <= {new_start, pn_r, pv_r};
    if (cmd.rd_look || cmd.rd_old) erd_r <= emem[e_ra];
  end

  assign start_ext = WW'(rd_start);

  // result item, fields that do not apply stay zero
  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = cmd.status;
    out_nxt.entry_count = 8'(16'(cnt_nxt));
    out_nxt.used_size   = used_nxt;
    case (cmd.kind)
      RK_STATIC: begin
        out_nxt.is_static   = 1'b1;
        out_nxt.static_slot = 6'(req_r.table_index - 8'd1);
      end
      RK_DYN: begin
        out_nxt.entry_start  = start_ext[11:0];
        out_nxt.name_length  = rd_nlen[11:0];
        out_nxt.value_length = req_r.name_only ? 12'd0 : rd_vlen[11:0];
      end
      RK_READ: out_nxt.read_data = brd_r;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAX_CNT)
    else $error("entry count beyond capacity");
  a_empty_used: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r == '0 |-> used_r == 13'd0)
    else $error("empty table with nonzero size");
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
      cmd.drop |-> cnt_r != '0)
    else $error("eviction from empty table");

endmodule
